>>> src/icmp_er_pkg.sv
package icmp_er_pkg;

    localparam int HDR_LEN  = 42;
    localparam int POS_W    = 6;
    localparam logic [POS_W-1:0] LAST_IDX    = POS_W'(HDR_LEN - 1);
    localparam logic [POS_W-1:0] PAYLOAD_POS = POS_W'(HDR_LEN);

    // Header layout, byte offsets from the start of the frame.
    localparam logic [POS_W-1:0] OFS_SRC_MAC    = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_MAC_END    = POS_W'(12);
    localparam logic [POS_W-1:0] OFS_ETYPE_HI   = POS_W'(12);
    localparam logic [POS_W-1:0] OFS_ETYPE_LO   = POS_W'(13);
    localparam logic [POS_W-1:0] OFS_IP_PROTO   = POS_W'(23);
    localparam logic [POS_W-1:0] OFS_SRC_IP     = POS_W'(26);
    localparam logic [POS_W-1:0] OFS_DST_IP     = POS_W'(30);
    localparam logic [POS_W-1:0] OFS_IP_END     = POS_W'(34);
    localparam logic [POS_W-1:0] OFS_ICMP_TYPE  = POS_W'(34);
    localparam logic [POS_W-1:0] OFS_ICMP_CS_HI = POS_W'(36);
    localparam logic [POS_W-1:0] OFS_ICMP_CS_LO = POS_W'(37);
    localparam logic [POS_W-1:0] MAC_LEN        = POS_W'(6);
    localparam logic [POS_W-1:0] IP_ADDR_LEN    = POS_W'(4);

    localparam logic [7:0]  ETYPE_IPV4_HI   = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO   = 8'h00;
    localparam logic [7:0]  IP_PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
    localparam logic [15:0] CSUM_ADJ        = 16'h0800;

    // Request passed from the classifier to the transmit side.
    typedef struct packed {
        logic        hdr;   // 1: emit the reply header, data holds the new checksum
        logic [15:0] data;  // payload byte in the low half otherwise
        logic        last;
    } t_cmd;

    // Write port into the header buffer.
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } t_hdr_wr;

endpackage

>>> src/icmp_er_fifo.sv
module icmp_er_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_valid
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= wrap_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= wrap_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

endmodule

>>> src/icmp_er_front.sv
module icmp_er_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output icmp_er_pkg::t_cmd    o_q_data,
    output icmp_er_pkg::t_hdr_wr o_hdr_wr,
    input  logic                 i_hdr_done
);
    import icmp_er_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_rej, n_rej;
    logic             r_ok, n_ok;
    logic             r_hdr_pend;
    logic [7:0]       r_cs_hi, r_cs_lo;
    logic             accept, in_hdr, chk, push_hdr, push_pay;
    logic [16:0]      sum;
    logic [15:0]      csum;

    assign in_hdr     = (r_pos <= LAST_IDX);
    // The header buffer is busy until the transmit side has read the previous header.
    assign o_in_ready = !(in_hdr && r_hdr_pend) && !((r_pos >= LAST_IDX) && i_q_full);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_pos)
            OFS_ETYPE_HI:  chk = (i_in_byte == ETYPE_IPV4_HI);
            OFS_ETYPE_LO:  chk = (i_in_byte == ETYPE_IPV4_LO);
            OFS_IP_PROTO:  chk = (i_in_byte == IP_PROTO_ICMP);
            OFS_ICMP_TYPE: chk = (i_in_byte == ICMP_ECHO_REQ);
            default:       chk = 1'b1;
        endcase
    end

    // One's-complement add with end-around carry; it cannot carry twice.
    assign sum  = {1'b0, r_cs_hi, r_cs_lo} + {1'b0, CSUM_ADJ};
    assign csum = sum[15:0] + {15'b0, sum[16]};

    assign push_hdr = accept && (r_pos == LAST_IDX) && r_ok;
    assign push_pay = accept && (r_pos == PAYLOAD_POS) && !r_rej;
    assign o_q_push = push_hdr || push_pay;

    always_comb begin
        o_q_data.hdr  = push_hdr;
        o_q_data.data = push_hdr ? csum : {8'b0, i_in_byte};
        o_q_data.last = i_in_last;
    end

    always_comb begin
        o_hdr_wr.en   = accept && in_hdr;
        o_hdr_wr.addr = r_pos;
        o_hdr_wr.data = i_in_byte;
    end

    always_comb begin
        n_pos = r_pos;
        n_rej = r_rej;
        n_ok  = r_ok;
        if (accept) begin
            if (in_hdr) begin
                n_ok = ((r_pos == '0) || r_ok) && chk;
            end
            if (r_pos < LAST_IDX) begin
                n_pos = i_in_last ? '0 : r_pos + POS_W'(1);
            end else if (r_pos == LAST_IDX) begin
                n_pos = i_in_last ? '0 : PAYLOAD_POS;
                n_rej = !i_in_last && !r_ok;
            end else if (i_in_last) begin
                n_pos = '0;
                n_rej = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rej      <= 1'b0;
            r_ok       <= 1'b0;
            r_hdr_pend <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_rej      <= n_rej;
            r_ok       <= n_ok;
            r_hdr_pend <= (r_hdr_pend || push_hdr) && !i_hdr_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_pos == OFS_ICMP_CS_HI)) begin
            r_cs_hi <= i_in_byte;
        end
        if (accept && (r_pos == OFS_ICMP_CS_LO)) begin
            r_cs_lo <= i_in_byte;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PAYLOAD_POS)
        else $error("byte position out of range");

    a_one_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_hdr |-> !r_hdr_pend)
        else $error("second header request while one is pending");

endmodule

>>> src/icmp_er_back.sv
module icmp_er_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  icmp_er_pkg::t_cmd    i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  icmp_er_pkg::t_hdr_wr i_hdr_wr,
    output logic                 o_hdr_done,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last
);
    import icmp_er_pkg::*;

    logic [7:0]       r_hdr_mem [HDR_LEN];
    logic [7:0]       r_rd_data;
    logic [POS_W-1:0] r_idx, n_idx;
    logic             r_hdr_act, n_hdr_act;
    logic             r_hdr_last;
    logic [15:0]      r_csum;
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_ol;
    logic             load, emit, e_last;
    logic [7:0]       e_byte, hdr_byte;

    // Source byte of the received header for each byte of the reply.
    function automatic logic [POS_W-1:0] src_of(input logic [POS_W-1:0] i);
        logic [POS_W-1:0] s;
        s = i;
        if (i < OFS_SRC_MAC) begin
            s = i + MAC_LEN;
        end else if (i < OFS_MAC_END) begin
            s = i - MAC_LEN;
        end else if ((i >= OFS_SRC_IP) && (i < OFS_DST_IP)) begin
            s = i + IP_ADDR_LEN;
        end else if ((i >= OFS_DST_IP) && (i < OFS_IP_END)) begin
            s = i - IP_ADDR_LEN;
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_hdr_wr.en) begin
            r_hdr_mem[i_hdr_wr.addr] <= i_hdr_wr.data;
        end
        r_rd_data <= r_hdr_mem[src_of(n_idx)];
    end

    assign load = !r_ov || i_out_ready;

    always_comb begin
        unique case (r_idx)
            OFS_ICMP_TYPE:  hdr_byte = ICMP_ECHO_REPLY;
            OFS_ICMP_CS_HI: hdr_byte = r_csum[15:8];
            OFS_ICMP_CS_LO: hdr_byte = r_csum[7:0];
            default:        hdr_byte = r_rd_data;
        endcase
    end

    always_comb begin
        n_idx      = r_idx;
        n_hdr_act  = r_hdr_act;
        o_cmd_pop  = 1'b0;
        o_hdr_done = 1'b0;
        emit       = 1'b0;
        e_byte     = i_cmd.data[7:0];
        e_last     = i_cmd.last;
        if (r_hdr_act) begin
            e_byte = hdr_byte;
            e_last = (r_idx == LAST_IDX) && r_hdr_last;
            if (load) begin
                emit = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_hdr_act  = 1'b0;
                    o_hdr_done = 1'b1;
                end else begin
                    n_idx = r_idx + POS_W'(1);
                end
            end
        end else if (i_cmd_valid && (i_cmd.hdr || load)) begin
            o_cmd_pop = 1'b1;
            if (i_cmd.hdr) begin
                n_hdr_act = 1'b1;
                n_idx     = '0;
            end else begin
                emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_hdr_act <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_hdr_act <= n_hdr_act;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob <= e_byte;
            r_ol <= e_last;
        end
        if (o_cmd_pop && i_cmd.hdr) begin
            r_csum     <= i_cmd.data;
            r_hdr_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_act |-> (r_idx <= LAST_IDX))
        else $error("header index out of range");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hdr_done |=> (!r_hdr_act && r_ov))
        else $error("header burst did not end after its final byte");

endmodule

>>> src/icmp_echo_responder.sv
// ICMP echo responder for IPv4 over Ethernet.
//
// The input channel (i_in_valid / o_in_ready) carries a received frame one byte
// per request, with i_in_last on the final byte. The output channel
// (o_out_valid / i_out_ready) carries the echo reply the same way.
// A classifier buffers the 42 header bytes in a header RAM and checks the
// ethertype, IP protocol and ICMP type on the fly. At byte 41 of a matching
// frame it queues a header request carrying the repaired ICMP checksum; later
// bytes are queued as payload requests. Non-matching and short frames are
// consumed without output.
// The transmit side plays back the header from the RAM with MACs and IPs
// swapped, then passes payload through, one byte per cycle while the receiver
// is ready, through an output register. The reply header starts once its
// header request has passed through the queue, and the next frame's header
// bytes wait until the previous reply header has been read out of the RAM.
// When the receiver stalls, the queue fills and then input stalls too.
// Reset (synchronous, active low) empties the queue and the output register
// and readies the block for the first byte of a new frame.
module icmp_echo_responder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import icmp_er_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic    q_push, q_full, q_valid, q_pop, hdr_done;
    t_cmd    q_wdata, q_rdata;
    t_hdr_wr hdr_wr;

    // Classifier: header capture, frame checks, request generation.
    icmp_er_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata),
        .o_hdr_wr   (hdr_wr),
        .i_hdr_done (hdr_done)
    );

    // Request queue between the classifier and the transmit side.
    icmp_er_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    // Transmit side: header RAM playback, payload pass-through, output register.
    icmp_er_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_rdata),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_hdr_wr    (hdr_wr),
        .o_hdr_done  (hdr_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

// Testbench for the ICMP echo responder.
//
// Frames are sent one byte per request on the input channel. A predictor keeps
// its own copy of the header buffer and the frame position. For every accepted
// input byte it works out which reply bytes the block must produce and queues
// them. The checker pops one expected byte for every reply byte that the
// receiver accepts and compares the data and the last flag.
module testbench;
    import icmp_er_pkg::*;

    // Cycles with no accepted request on either channel before the run is
    // declared hung. This is far above the receiver hold-off and any random gap.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles run after the last expected reply byte, so that any further,
    // unexpected reply byte from the output register still reaches the checker.
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 300;

    // The four header fields that decide whether a frame is an echo request.
    typedef enum int {
        CHK_ETYPE_HI,
        CHK_ETYPE_LO,
        CHK_IP_PROTO,
        CHK_ICMP_TYPE
    } t_check_field;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_byte;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    // Predictor state: buffered header, header position and the drop flag
    // for a frame that failed the echo request checks.
    logic [7:0] hdr_img [HDR_LEN];
    logic [5:0] hdr_pos    = '0;
    logic       frame_drop = 1'b0;

    t_reply_byte reply_q[$];
    logic [7:0]  frame_buf[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    int err_count     = 0;
    int stall_cycles  = 0;

    icmp_echo_responder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Works out the reply bytes that one accepted input byte causes. Header
    // bytes are only buffered; the byte that completes the header either
    // releases the whole reply header or marks the frame as dropped. After
    // that, payload bytes of a good frame pass straight through.
    function automatic void predict_reply(input logic [7:0] b, input logic last);
        logic [16:0] sum;
        logic [15:0] csum;
        t_reply_byte r;
        int src;
        bit is_req;
        if (hdr_pos < LAST_IDX) begin
            hdr_img[hdr_pos] = b;
            hdr_pos = last ? '0 : hdr_pos + 6'd1;
        end else if (hdr_pos == LAST_IDX) begin
            hdr_img[LAST_IDX] = b;
            is_req = hdr_img[OFS_ETYPE_HI] == ETYPE_IPV4_HI &&
                     hdr_img[OFS_ETYPE_LO] == ETYPE_IPV4_LO &&
                     hdr_img[OFS_IP_PROTO] == IP_PROTO_ICMP &&
                     hdr_img[OFS_ICMP_TYPE] == ICMP_ECHO_REQ;
            if (!is_req) begin
                frame_drop = !last;
                hdr_pos = last ? '0 : PAYLOAD_POS;
                return;
            end
            // The type changes from 8 to 0, so the checksum gains 0x0800 in
            // one's-complement arithmetic, carry folded back in.
            sum  = {1'b0, hdr_img[OFS_ICMP_CS_HI], hdr_img[OFS_ICMP_CS_LO]} +
                   {1'b0, CSUM_ADJ};
            csum = sum[15:0] + 16'(sum[16]);
            for (int i = 0; i < HDR_LEN; i++) begin
                if (i < OFS_SRC_MAC)
                    src = i + MAC_LEN;
                else if (i < OFS_MAC_END)
                    src = i - MAC_LEN;
                else if (i >= OFS_SRC_IP && i < OFS_DST_IP)
                    src = i + IP_ADDR_LEN;
                else if (i >= OFS_DST_IP && i < OFS_IP_END)
                    src = i - IP_ADDR_LEN;
                else
                    src = i;
                r.data = hdr_img[src];
                if (i == OFS_ICMP_TYPE)
                    r.data = ICMP_ECHO_REPLY;
                else if (i == OFS_ICMP_CS_HI)
                    r.data = csum[15:8];
                else if (i == OFS_ICMP_CS_LO)
                    r.data = csum[7:0];
                r.last = (i == LAST_IDX) && last;
                reply_q.push_back(r);
            end
            hdr_pos = last ? '0 : PAYLOAD_POS;
        end else begin
            if (!frame_drop) begin
                r.data = b;
                r.last = last;
                reply_q.push_back(r);
            end
            if (last) begin
                hdr_pos = '0;
                frame_drop = 1'b0;
            end
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off on request that is
    // counted down here so the sender keeps pushing into a full block.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Reply checker. Every accepted reply byte must match the oldest
    // expectation; a byte with nothing expected is an error too.
    always @(posedge i_clk) begin
        t_reply_byte exp_b;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_q.size() == 0) begin
                err_count++;
                if (err_count <= 50)
                    $display("%0t: unexpected reply byte, expected none, got %h last %b",
                             $time, o_out_byte, o_out_last);
            end else begin
                exp_b = reply_q.pop_front();
                if (o_out_byte !== exp_b.data) begin
                    err_count++;
                    if (err_count <= 50)
                        $display("%0t: reply byte mismatch, expected %h, got %h",
                                 $time, exp_b.data, o_out_byte);
                end
                if (o_out_last !== exp_b.last) begin
                    err_count++;
                    if (err_count <= 50)
                        $display("%0t: reply last mismatch, expected %b, got %b",
                                 $time, exp_b.last, o_out_last);
                end
            end
        end
    end

    // Watchdog: a run that stops moving on both channels has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offers one request, with a random gap first, and waits for it to be
    // taken. Valid stays high on return so back-to-back bytes have no gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predict_reply(b, last);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_buf.size(); k++)
            send_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // Fills the frame buffer with random bytes. For an echo request the
    // checked fields get their matching values, as far as the frame reaches.
    function automatic void build_frame(input int len, input bit echo);
        frame_buf.delete();
        for (int k = 0; k < len; k++)
            frame_buf.push_back(8'($urandom_range(255)));
        if (echo) begin
            if (len > OFS_ETYPE_HI)
                frame_buf[OFS_ETYPE_HI] = ETYPE_IPV4_HI;
            if (len > OFS_ETYPE_LO)
                frame_buf[OFS_ETYPE_LO] = ETYPE_IPV4_LO;
            if (len > OFS_IP_PROTO)
                frame_buf[OFS_IP_PROTO] = IP_PROTO_ICMP;
            if (len > OFS_ICMP_TYPE)
                frame_buf[OFS_ICMP_TYPE] = ICMP_ECHO_REQ;
        end
    endfunction

    // Spoils one of the checked fields so that the frame is no echo request.
    function automatic void spoil_field(input t_check_field fld);
        int idx;
        case (fld)
            CHK_ETYPE_HI: idx = OFS_ETYPE_HI;
            CHK_ETYPE_LO: idx = OFS_ETYPE_LO;
            CHK_IP_PROTO: idx = OFS_IP_PROTO;
            default:      idx = OFS_ICMP_TYPE;
        endcase
        frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
    endfunction

    function automatic void set_icmp_csum(input logic [15:0] cs);
        frame_buf[OFS_ICMP_CS_HI] = cs[15:8];
        frame_buf[OFS_ICMP_CS_LO] = cs[7:0];
    endfunction

    // A short frame, a header-only reply whose checksum wraps around, and a
    // rejected frame whose payload must be swallowed.
    task automatic test_directed_frames();
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // A one-byte frame is dropped without a reply.
        build_frame(1, 1'b0);
        send_frame();

        // Header-only echo request with all other bytes at 0xFF; the checksum
        // 0xFFFF wraps around to 0x0800.
        build_frame(0, 1'b0);
        for (int k = 0; k < HDR_LEN; k++)
            frame_buf.push_back(8'hFF);
        frame_buf[OFS_ETYPE_HI]  = ETYPE_IPV4_HI;
        frame_buf[OFS_ETYPE_LO]  = ETYPE_IPV4_LO;
        frame_buf[OFS_IP_PROTO]  = IP_PROTO_ICMP;
        frame_buf[OFS_ICMP_TYPE] = ICMP_ECHO_REQ;
        send_frame();

        // An echo reply instead of a request, with a payload that must be
        // ignored up to the last byte.
        build_frame(HDR_LEN + 2, 1'b1);
        frame_buf[OFS_ICMP_TYPE] = ICMP_ECHO_REPLY;
        send_frame();
    endtask

    // Mostly echo requests with random content and payload, the rest broken
    // requests, short frames and random noise of header length or more.
    task automatic test_random_frames(input int snd_pct, input int rcv_pct,
                                      input int frame_count);
        int pick;
        int plen;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int f = 0; f < frame_count; f++) begin
            pick = $urandom_range(99);
            plen = $urandom_range(4);
            if (pick < 65) begin
                build_frame(HDR_LEN + plen, 1'b1);
            end else if (pick < 82) begin
                build_frame(HDR_LEN + plen, 1'b1);
                spoil_field(t_check_field'($urandom_range(3)));
            end else if (pick < 92) begin
                build_frame($urandom_range(1, HDR_LEN - 1), 1'($urandom_range(1)));
            end else begin
                build_frame(HDR_LEN + plen, 1'b0);
            end
            send_frame();
        end
    endtask

    // The receiver holds off for a long stretch while a long echo request is
    // offered at full rate, so the queue fills and the input side stalls.
    // Its checksum sits at the point where the repair carries around.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        build_frame(HDR_LEN + 8, 1'b1);
        set_icmp_csum(16'hF800);
        send_frame();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_random_frames(36, 56, 1);
        test_random_frames(56, 36, 1);
        test_random_frames(0, 0, 1);
        test_backpressure();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
